// ===== hdl/sliding_window_sender_tracker_top_defines.svh =====
// assertion macros for the sliding window sender tracker checker
// expects clk and rst_n in the scope where a macro is used
`ifndef SLIDING_WINDOW_SENDER_TRACKER_TOP_DEFINES_SVH
`define SLIDING_WINDOW_SENDER_TRACKER_TOP_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SWST_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swst check failed");

// next-cycle implication, quiet during reset
`define SWST_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swst check failed");

`endif

// ===== hdl/swst_pkg.sv =====
// shared types, codes and sizes for the sliding window sender tracker
// no dependencies
`timescale 1ns / 1ps

package swst_pkg;

  localparam int MAX_SEGMENTS = 64;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = 7;
  localparam int SUM_W        = 8;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] KIND_SEND = 2'd0;
  localparam logic [1:0] KIND_NONE = 2'd1;
  localparam logic [1:0] KIND_ACK  = 2'd2;
  localparam logic [1:0] KIND_BAD  = 2'd3;

  localparam logic [1:0] ST_UNSENT = 2'd0;
  localparam logic [1:0] ST_SENT   = 2'd1;
  localparam logic [1:0] ST_ACKED  = 2'd2;

  localparam logic CMD_ACK  = 1'b0;
  localparam logic CMD_SEND = 1'b1;

  typedef enum logic [1:0] {
    OP_ACK,
    OP_BAD,
    OP_SEND
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [IDX_W-1:0] ack;
  } cmd_item_t;

  typedef struct packed {
    logic      valid;
    cmd_item_t item;
  } q_head_t;

endpackage

// ===== hdl/sliding_window_sender_tracker_top.sv =====
// Selective-repeat sender window tracker. Commands are taken on start while
// busy is low and wait in a two-entry queue; a sequencer then walks a 64-entry
// segment status ram, reading and then evaluating each entry. After a command
// leaves the queue, an ack marks its entry acked and then runs a window scan,
// a base slide, a next slide and a second window scan; a bad ack runs the
// window scan alone; a send round marks the unsent entries between next and
// the window end as sent, runs a window scan and then emits each one. Each
// result is presented for exactly one cycle with out_valid high and cannot
// be held off; results of one command never come back to back and the final
// one carries out_last. The segment count port is always ready and must only
// be written while no command is in flight. No clearing pass follows reset.
// depends on swst_pkg, swst_front, swst_back
`timescale 1ns / 1ps

module sliding_window_sender_tracker_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [swst_pkg::CNT_W-1:0]  cfg_segment_count,
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_command,
  input  logic [swst_pkg::IDX_W-1:0]  in_ack_seq,
  output logic                        out_valid,
  output logic [1:0]                  out_kind,
  output logic [swst_pkg::IDX_W-1:0]  out_seq,
  output logic [swst_pkg::IDX_W-1:0]  out_window_base,
  output logic [swst_pkg::CNT_W-1:0]  out_window_length,
  output logic [swst_pkg::CNT_W-1:0]  out_next_pointer,
  output logic                        out_finished,
  output logic                        out_last
);

  swst_pkg::q_head_t          head;
  logic                       pop;
  logic [swst_pkg::CNT_W-1:0] cnt;

  swst_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_segment_count (cfg_segment_count),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_ack_seq        (in_ack_seq),
    .head              (head),
    .pop               (pop),
    .cnt               (cnt)
  );

  swst_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .pop               (pop),
    .cnt               (cnt),
    .out_valid         (out_valid),
    .out_kind          (out_kind),
    .out_seq           (out_seq),
    .out_window_base   (out_window_base),
    .out_window_length (out_window_length),
    .out_next_pointer  (out_next_pointer),
    .out_finished      (out_finished),
    .out_last          (out_last)
  );

endmodule

// ===== hdl/swst_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module swst_ram #(
  parameter  int WIDTH = 2,
  parameter  int DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== hdl/swst_front.sv =====
// front end: segment count register, command classification and command queue
// depends on swst_pkg
`timescale 1ns / 1ps

module swst_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [swst_pkg::CNT_W-1:0]    cfg_segment_count,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_command,
  input  logic [swst_pkg::IDX_W-1:0]    in_ack_seq,
  output swst_pkg::q_head_t             head,
  input  logic                          pop,
  output logic [swst_pkg::CNT_W-1:0]    cnt
);

  logic [swst_pkg::CNT_W-1:0]  cnt_r;
  logic [swst_pkg::CNT_W-1:0]  cnt_nxt;
  swst_pkg::cmd_item_t         q_r [swst_pkg::QUEUE_DEPTH];
  logic [swst_pkg::QPTR_W-1:0] wr_ptr_r;
  logic [swst_pkg::QPTR_W-1:0] rd_ptr_r;
  logic [swst_pkg::QPTR_W:0]   fill_r;
  swst_pkg::cmd_item_t         item;
  logic                        push;
  logic                        do_pop;

  // out-of-range counts are folded to the nearest legal value on write
  always_comb begin
    if (cfg_segment_count == '0) begin
      cnt_nxt = swst_pkg::CNT_W'(1);
    end else if (cfg_segment_count > swst_pkg::CNT_W'(swst_pkg::MAX_SEGMENTS)) begin
      cnt_nxt = swst_pkg::CNT_W'(swst_pkg::MAX_SEGMENTS);
    end else begin
      cnt_nxt = cfg_segment_count;
    end
  end

  always_comb begin
    item.ack = in_ack_seq;
    if (in_command == swst_pkg::CMD_SEND) begin
      item.op = swst_pkg::OP_SEND;
    end else if ({1'b0, in_ack_seq} >= cnt_r) begin
      item.op = swst_pkg::OP_BAD;
    end else begin
      item.op = swst_pkg::OP_ACK;
    end
  end

  assign cfg_ready  = 1'b1;
  assign cnt        = cnt_r;
  assign busy       = (fill_r == (swst_pkg::QPTR_W + 1)'(swst_pkg::QUEUE_DEPTH));
  assign push       = start && !busy;
  assign do_pop     = pop && (fill_r != '0);
  assign head.valid = (fill_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= swst_pkg::CNT_W'(1);
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        cnt_r <= cnt_nxt;
      end
      if (push) begin
        wr_ptr_r <= wr_ptr_r + swst_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + swst_pkg::QPTR_W'(1);
      end
      if (push && !do_pop) begin
        fill_r <= fill_r + (swst_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !push) begin
        fill_r <= fill_r - (swst_pkg::QPTR_W + 1)'(1);
      end
    end
    if (push) begin
      q_r[wr_ptr_r] <= item;
    end
  end

endmodule

// ===== hdl/swst_back.sv =====
// back end: sequencer that walks the segment status ram and emits results
// depends on swst_pkg and swst_ram
`timescale 1ns / 1ps

module swst_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swst_pkg::q_head_t           head,
  output logic                        pop,
  input  logic [swst_pkg::CNT_W-1:0]  cnt,
  output logic                        out_valid,
  output logic [1:0]                  out_kind,
  output logic [swst_pkg::IDX_W-1:0]  out_seq,
  output logic [swst_pkg::IDX_W-1:0]  out_window_base,
  output logic [swst_pkg::CNT_W-1:0]  out_window_length,
  output logic [swst_pkg::CNT_W-1:0]  out_next_pointer,
  output logic                        out_finished,
  output logic                        out_last
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACK_WR,
    S_FIN_CHK,
    S_FIN_RD,
    S_FIN_EV,
    S_BASE_RD,
    S_BASE_EV,
    S_NEXT_RD,
    S_NEXT_EV,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SEND_END,
    S_LIST_RD,
    S_LIST_EV
  } state_t;

  state_t                            state_r, state_nxt;
  swst_pkg::op_t                     op_r, op_nxt;
  logic [swst_pkg::IDX_W-1:0]        ack_r, ack_nxt;
  logic [swst_pkg::IDX_W-1:0]        base_r, base_nxt;
  logic [swst_pkg::CNT_W-1:0]        win_r, win_nxt;
  logic [swst_pkg::CNT_W-1:0]        next_r, next_nxt;
  logic [swst_pkg::CNT_W-1:0]        idx_r, idx_nxt;
  logic [swst_pkg::CNT_W-1:0]        n_r, n_nxt;
  logic                              grow_r, grow_nxt;
  logic                              fin_r, fin_nxt;
  logic [swst_pkg::MAX_SEGMENTS-1:0] vld_r, vld_nxt;
  logic                              rd_vld_r;
  logic                              out_valid_r, out_valid_nxt;
  logic [1:0]                        out_kind_r, out_kind_nxt;
  logic [swst_pkg::IDX_W-1:0]        out_seq_r, out_seq_nxt;
  logic                              out_last_r, out_last_nxt;

  logic                              st_we;
  logic [swst_pkg::IDX_W-1:0]        st_waddr;
  logic [1:0]                        st_wdata;
  logic [swst_pkg::IDX_W-1:0]        rd_addr;
  logic [1:0]                        st_rdata;
  logic [1:0]                        rd_status;
  logic                              ls_we;
  logic [swst_pkg::IDX_W-1:0]        ls_waddr;
  logic [swst_pkg::IDX_W-1:0]        ls_wdata;
  logic [swst_pkg::IDX_W-1:0]        ls_raddr;
  logic [swst_pkg::IDX_W-1:0]        ls_rdata;
  logic                              fin_done;
  logic                              fin_val;

  logic [swst_pkg::SUM_W-1:0]        sum_bw;
  logic [swst_pkg::SUM_W-1:0]        cnt_w;
  logic [swst_pkg::SUM_W-1:0]        fin_p;
  logic [swst_pkg::SUM_W-1:0]        next_inc;
  logic [swst_pkg::SUM_W-1:0]        idx_w;

  swst_ram #(
    .WIDTH (2),
    .DEPTH (swst_pkg::MAX_SEGMENTS)
  ) u_status_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (rd_addr),
    .rdata (st_rdata)
  );

  // indexes of the segments picked in the current send round
  swst_ram #(
    .WIDTH (swst_pkg::IDX_W),
    .DEPTH (swst_pkg::MAX_SEGMENTS)
  ) u_list_ram (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata (ls_wdata),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  // never-written entries read as unsent
  assign rd_status = rd_vld_r ? st_rdata : swst_pkg::ST_UNSENT;

  assign sum_bw   = swst_pkg::SUM_W'(base_r) + swst_pkg::SUM_W'(win_r);
  assign cnt_w    = swst_pkg::SUM_W'(cnt);
  assign fin_p    = swst_pkg::SUM_W'(base_r) + swst_pkg::SUM_W'(idx_r);
  assign next_inc = swst_pkg::SUM_W'(next_r) + swst_pkg::SUM_W'(1);
  assign idx_w    = swst_pkg::SUM_W'(idx_r);

  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ack_nxt       = ack_r;
    base_nxt      = base_r;
    win_nxt       = win_r;
    next_nxt      = next_r;
    idx_nxt       = idx_r;
    n_nxt         = n_r;
    grow_nxt      = grow_r;
    fin_nxt       = fin_r;
    vld_nxt       = vld_r;
    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_last_nxt  = out_last_r;
    pop           = 1'b0;
    st_we         = 1'b0;
    st_waddr      = ack_r;
    st_wdata      = swst_pkg::ST_ACKED;
    rd_addr       = '0;
    ls_we         = 1'b0;
    ls_waddr      = n_r[swst_pkg::IDX_W-1:0];
    ls_wdata      = idx_r[swst_pkg::IDX_W-1:0];
    ls_raddr      = idx_r[swst_pkg::IDX_W-1:0];
    fin_done      = 1'b0;
    fin_val       = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          pop      = 1'b1;
          op_nxt   = head.item.op;
          ack_nxt  = head.item.ack;
          n_nxt    = '0;
          idx_nxt  = next_r;
          grow_nxt = (head.item.op == swst_pkg::OP_ACK);
          unique case (head.item.op)
            swst_pkg::OP_ACK:  state_nxt = S_ACK_WR;
            swst_pkg::OP_BAD:  state_nxt = S_FIN_CHK;
            swst_pkg::OP_SEND: state_nxt = S_SCAN_RD;
            default:           state_nxt = S_IDLE;
          endcase
        end
      end
      S_ACK_WR: begin
        st_we          = 1'b1;
        vld_nxt[ack_r] = 1'b1;
        state_nxt      = S_FIN_CHK;
      end
      S_FIN_CHK: begin
        idx_nxt = '0;
        if (sum_bw + swst_pkg::SUM_W'(1) < cnt_w) begin
          fin_done = 1'b1;
        end else begin
          state_nxt = S_FIN_RD;
        end
      end
      S_FIN_RD: begin
        if (idx_r >= win_r || fin_p >= cnt_w) begin
          fin_done = 1'b1;
          fin_val  = 1'b1;
        end else begin
          rd_addr   = fin_p[swst_pkg::IDX_W-1:0];
          state_nxt = S_FIN_EV;
        end
      end
      S_FIN_EV: begin
        if (rd_status != swst_pkg::ST_ACKED) begin
          fin_done = 1'b1;
        end else begin
          idx_nxt   = idx_r + swst_pkg::CNT_W'(1);
          state_nxt = S_FIN_RD;
        end
      end
      S_BASE_RD: begin
        if (sum_bw < cnt_w) begin
          rd_addr   = base_r;
          state_nxt = S_BASE_EV;
        end else begin
          state_nxt = S_NEXT_RD;
        end
      end
      S_BASE_EV: begin
        if (rd_status == swst_pkg::ST_ACKED) begin
          base_nxt  = base_r + swst_pkg::IDX_W'(1);
          state_nxt = S_BASE_RD;
        end else begin
          state_nxt = S_NEXT_RD;
        end
      end
      S_NEXT_RD: begin
        if (next_inc < cnt_w) begin
          rd_addr   = next_r[swst_pkg::IDX_W-1:0];
          state_nxt = S_NEXT_EV;
        end else begin
          state_nxt = S_FIN_CHK;
        end
      end
      S_NEXT_EV: begin
        if (rd_status != swst_pkg::ST_UNSENT) begin
          next_nxt  = next_r + swst_pkg::CNT_W'(1);
          state_nxt = S_NEXT_RD;
        end else begin
          state_nxt = S_FIN_CHK;
        end
      end
      S_SCAN_RD: begin
        if (idx_w < sum_bw && idx_w < cnt_w) begin
          rd_addr   = idx_r[swst_pkg::IDX_W-1:0];
          state_nxt = S_SCAN_EV;
        end else begin
          state_nxt = S_SEND_END;
        end
      end
      S_SCAN_EV: begin
        if (rd_status == swst_pkg::ST_UNSENT) begin
          st_we    = 1'b1;
          st_waddr = idx_r[swst_pkg::IDX_W-1:0];
          st_wdata = swst_pkg::ST_SENT;
          vld_nxt[idx_r[swst_pkg::IDX_W-1:0]] = 1'b1;
          ls_we    = 1'b1;
          n_nxt    = n_r + swst_pkg::CNT_W'(1);
        end
        idx_nxt   = idx_r + swst_pkg::CNT_W'(1);
        state_nxt = S_SCAN_RD;
      end
      S_SEND_END: begin
        // sending the last segment pushes the pointer to the end
        if (n_r != '0 && next_inc == cnt_w) begin
          next_nxt = cnt;
        end
        state_nxt = S_FIN_CHK;
      end
      S_LIST_RD: begin
        state_nxt = S_LIST_EV;
      end
      S_LIST_EV: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = swst_pkg::KIND_SEND;
        out_seq_nxt   = ls_rdata;
        out_last_nxt  = ((idx_r + swst_pkg::CNT_W'(1)) == n_r);
        idx_nxt       = idx_r + swst_pkg::CNT_W'(1);
        state_nxt     = out_last_nxt ? S_IDLE : S_LIST_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (fin_done) begin
      if (grow_r) begin
        grow_nxt = 1'b0;
        if (!fin_val && sum_bw < cnt_w) begin
          win_nxt = win_r + swst_pkg::CNT_W'(1);
        end
        state_nxt = S_BASE_RD;
      end else begin
        fin_nxt = fin_val;
        if (op_r == swst_pkg::OP_SEND && n_r != '0) begin
          idx_nxt   = '0;
          state_nxt = S_LIST_RD;
        end else begin
          out_valid_nxt = 1'b1;
          out_seq_nxt   = '0;
          out_last_nxt  = 1'b1;
          unique case (op_r)
            swst_pkg::OP_ACK: out_kind_nxt = swst_pkg::KIND_ACK;
            swst_pkg::OP_BAD: out_kind_nxt = swst_pkg::KIND_BAD;
            default:          out_kind_nxt = swst_pkg::KIND_NONE;
          endcase
          state_nxt = S_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= '0;
      win_r       <= swst_pkg::CNT_W'(1);
      next_r      <= '0;
      vld_r       <= '0;
      grow_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      base_r      <= base_nxt;
      win_r       <= win_nxt;
      next_r      <= next_nxt;
      vld_r       <= vld_nxt;
      grow_r      <= grow_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r       <= op_nxt;
    ack_r      <= ack_nxt;
    idx_r      <= idx_nxt;
    n_r        <= n_nxt;
    fin_r      <= fin_nxt;
    rd_vld_r   <= vld_r[rd_addr];
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = out_kind_r;
  assign out_seq           = out_seq_r;
  assign out_window_base   = base_r;
  assign out_window_length = win_r;
  assign out_next_pointer  = next_r;
  assign out_finished      = fin_r;
  assign out_last          = out_last_r;

endmodule

// ===== hdl/swst_checker.sv =====
// port-level checks for the sender window tracker, bound to the top level
// depends on swst_pkg and sliding_window_sender_tracker_top_defines.svh
`timescale 1ns / 1ps
`include "sliding_window_sender_tracker_top_defines.svh"

module swst_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic [1:0]                  out_kind,
  input logic [swst_pkg::IDX_W-1:0]  out_seq,
  input logic [swst_pkg::IDX_W-1:0]  out_window_base,
  input logic [swst_pkg::CNT_W-1:0]  out_window_length,
  input logic                        out_last
);

  logic [swst_pkg::SUM_W-1:0] win_end;
  logic [swst_pkg::SUM_W-1:0] seq_w;

  assign win_end = swst_pkg::SUM_W'(out_window_base) + swst_pkg::SUM_W'(out_window_length);
  assign seq_w   = swst_pkg::SUM_W'(out_seq);

  `SWST_ASSERT_IMP(a_single_is_last, out_valid && (out_kind != swst_pkg::KIND_SEND), out_last)
  `SWST_ASSERT_IMP(a_seq_in_window, out_valid && (out_kind == swst_pkg::KIND_SEND), seq_w < win_end)
  `SWST_ASSERT_IMP(a_window_bound, out_valid, win_end <= swst_pkg::SUM_W'(swst_pkg::MAX_SEGMENTS))
  `SWST_ASSERT_NXT(a_strobe_gap, out_valid, !out_valid)

endmodule

bind sliding_window_sender_tracker_top swst_checker u_swst_checker (.*);
